/* hw/rtl/ecc_pkg.sv */
// Shared types, constants and arithmetic helpers for the epoch calendar converter.
`timescale 1ns / 1ps
package ecc_pkg;

  localparam int unsigned SecPerDay   = 86400;
  localparam int unsigned JdnUnixBase = 2440588;

  localparam logic ModeSplit = 1'b0;
  localparam logic ModeAdd   = 1'b1;

  localparam int unsigned ToEpochStages = 3;
  localparam int unsigned SplitStages   = 7;

  typedef struct packed {
    logic              mode;
    logic [31:0]       epoch_in;
    logic signed [7:0] year_in;
    logic [3:0]        month_in;
    logic [4:0]        day_in;
    logic [4:0]        hour_in;
    logic [5:0]        minute_in;
    logic [5:0]        second_in;
    logic [31:0]       add_amount;
  } req_t;

  typedef struct packed {
    logic [31:0]       epoch_out;
    logic signed [7:0] year_out;
    logic [3:0]        month_out;
    logic [4:0]        day_out;
    logic [4:0]        hour_out;
    logic [5:0]        minute_out;
    logic [5:0]        second_out;
  } rsp_t;

  // Days from 1 March to the start of March-based month m: (153 m + 2) / 5
  function automatic logic [8:0] month_days(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd398;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ecc_if.sv */
// Valid/ready channel interface carrying one request or response.
`timescale 1ns / 1ps
interface ecc_req_if;
  logic          valid;
  logic          ready;
  ecc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ecc_rsp_if;
  logic          valid;
  logic          ready;
  ecc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ecc_to_epoch.sv */
// Fields to epoch seconds: three register stages, advancing under a shared enable.
`timescale 1ns / 1ps
module ecc_to_epoch (
  input  logic          clk_i,
  input  logic          en_i,
  input  ecc_pkg::req_t req_i,
  output logic [31:0]   epoch_o
);
  // Stage A: March-based year and month, small terms
  logic [12:0] y_d, y_q;
  logic [3:0]  m_d;
  logic [8:0]  mdays_d, mdays_q;
  logic [16:0] hms_d, hms_q;
  logic        mode_q;
  logic [31:0] epoch_q, add_q;
  logic        early;

  always_comb begin
    early   = (req_i.month_in <= 4'd2);
    y_d     = 13'(14'(signed'(req_i.year_in)) + 14'sd6800) - {12'd0, early};
    m_d     = 4'(req_i.month_in + (early ? 4'd12 : 4'd0) - 4'd3);
    mdays_d = ecc_pkg::month_days(m_d) + {4'd0, req_i.day_in};
    hms_d   = 17'({12'd0, req_i.hour_in} * 17'd3600) + 17'({11'd0, req_i.minute_in} * 17'd60)
            + {11'd0, req_i.second_in};
  end

  // Stage B: day number from year; y / 100 as (y * 5243) >> 19, exact below 8192
  logic [31:0] days_d, days_q, hms2_q, add2_q, ep2_q;
  logic        mode2_q;
  logic [25:0] cent_prod;
  logic [6:0]  cent;
  always_comb begin
    cent_prod = {13'd0, y_q} * 26'd5243;
    cent      = cent_prod[25:19];
    days_d = 32'd365 * {19'd0, y_q} + {21'd0, y_q[12:2]}
           - {25'd0, cent} + {27'd0, cent[6:2]}
           + {23'd0, mdays_q} - 32'd32045 - 32'(ecc_pkg::JdnUnixBase);
  end

  // Stage C: seconds
  logic [31:0] sum_d, sum_q;
  always_comb sum_d = (mode2_q == ecc_pkg::ModeAdd)
                    ? (days_q * 32'(ecc_pkg::SecPerDay) + hms2_q + add2_q) : ep2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q     <= y_d;
      mdays_q <= mdays_d;
      hms_q   <= hms_d;
      mode_q  <= req_i.mode;
      epoch_q <= req_i.epoch_in;
      add_q   <= req_i.add_amount;
      days_q  <= days_d;
      hms2_q  <= {15'd0, hms_q};
      add2_q  <= add_q;
      ep2_q   <= epoch_q;
      mode2_q <= mode_q;
      sum_q   <= sum_d;
    end
  end
  assign epoch_o = sum_q;
endmodule

/* hw/rtl/ecc_split.sv */
// Epoch seconds to calendar fields: seven register stages under a shared enable.
`timescale 1ns / 1ps
module ecc_split (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [31:0]   epoch_i,
  output ecc_pkg::rsp_t rsp_o
);
  // Reciprocals: x / d is (x * K) >> S, exact over the range each operand reaches
  localparam logic [25:0] RecipDay  = 26'd50903317; // (t >> 7) / 675, S = 35
  localparam logic [15:0] RecipMin  = 16'd34953;    // (tod >> 2) / 15, S = 19
  localparam logic [13:0] RecipHour = 14'd9321;     // (tod >> 4) / 225, S = 21
  localparam logic [17:0] RecipYear = 18'd183735;   // x / 1461, S = 28
  localparam logic [10:0] RecipMon  = 11'd1714;     // x / 153, S = 18

  // Stage 1: day count
  logic [31:0] t1_q;
  logic [15:0] dn1_q;
  logic [50:0] dn_prod;
  always_comb dn_prod = {26'd0, epoch_i[31:7]} * {25'd0, RecipDay};
  always_ff @(posedge clk_i) if (en_i) begin
    t1_q  <= epoch_i;
    dn1_q <= dn_prod[50:35];
  end

  // Stage 2: day number from the calendar origin and time of day
  logic [31:0] t2_q;
  logic [22:0] a2_q;
  logic [16:0] tod2_q;
  always_ff @(posedge clk_i) if (en_i) begin
    t2_q   <= t1_q;
    a2_q   <= {7'd0, dn1_q} + 23'(ecc_pkg::JdnUnixBase) + 23'd32044;
    tod2_q <= 17'(t1_q - {16'd0, dn1_q} * 32'(ecc_pkg::SecPerDay));
  end

  // Stage 3: era and day of era, minutes and hours of the day
  logic [31:0] t3_q;
  logic [6:0]  b3_q;
  logic [15:0] c3_q;
  logic [16:0] tod3_q;
  logic [10:0] mins3_q;
  logic [4:0]  h3_q;
  logic [24:0] a4;
  logic [6:0]  b;
  logic [22:0] era_start;
  logic [30:0] mins_prod;
  logic [26:0] hour_prod;
  always_comb begin
    a4 = {a2_q, 2'b11};
    // The 32-bit epoch span only reaches eras 67 to 69
    if (a4 >= 25'd10080693) begin
      b         = 7'd69;
      era_start = 23'd2520173;
    end else if (a4 >= 25'd9934596) begin
      b         = 7'd68;
      era_start = 23'd2483649;
    end else begin
      b         = 7'd67;
      era_start = 23'd2447124;
    end
    mins_prod = {16'd0, tod2_q[16:2]} * {15'd0, RecipMin};
    hour_prod = {14'd0, tod2_q[16:4]} * {13'd0, RecipHour};
  end
  always_ff @(posedge clk_i) if (en_i) begin
    t3_q    <= t2_q;
    b3_q    <= b;
    c3_q    <= 16'(a2_q - era_start);
    tod3_q  <= tod2_q;
    mins3_q <= mins_prod[29:19];
    h3_q    <= hour_prod[25:21];
  end

  // Stage 4: year within era, seconds and minutes
  logic [31:0] t4_q;
  logic [6:0]  b4_q, d4_q;
  logic [15:0] c4_q;
  logic [4:0]  h4_q;
  logic [5:0]  mi4_q, s4_q;
  logic [35:0] yr_prod;
  always_comb yr_prod = {18'd0, c3_q, 2'b11} * {18'd0, RecipYear};
  always_ff @(posedge clk_i) if (en_i) begin
    t4_q  <= t3_q;
    b4_q  <= b3_q;
    c4_q  <= c3_q;
    d4_q  <= yr_prod[34:28];
    h4_q  <= h3_q;
    mi4_q <= 6'(mins3_q - {6'd0, h3_q} * 11'd60);
    s4_q  <= 6'(tod3_q - {6'd0, mins3_q} * 17'd60);
  end

  // Stage 5: day of March-based year
  logic [31:0] t5_q;
  logic [6:0]  b5_q, d5_q;
  logic [8:0]  e5_q;
  logic [4:0]  h5_q;
  logic [5:0]  mi5_q, s5_q;
  logic [17:0] yr_days;
  always_comb yr_days = {11'd0, d4_q} * 18'd1461;
  always_ff @(posedge clk_i) if (en_i) begin
    t5_q  <= t4_q;
    b5_q  <= b4_q;
    d5_q  <= d4_q;
    e5_q  <= 9'(c4_q - yr_days[17:2]);
    h5_q  <= h4_q;
    mi5_q <= mi4_q;
    s5_q  <= s4_q;
  end

  // Stage 6: March-based month
  logic [31:0] t6_q;
  logic [6:0]  b6_q, d6_q;
  logic [8:0]  e6_q;
  logic [3:0]  m6_q;
  logic [4:0]  h6_q;
  logic [5:0]  mi6_q, s6_q;
  logic [10:0] e5x;
  logic [21:0] mon_prod;
  always_comb begin
    e5x      = {2'd0, e5_q} * 11'd5 + 11'd2;
    mon_prod = {11'd0, e5x} * {11'd0, RecipMon};
  end
  always_ff @(posedge clk_i) if (en_i) begin
    t6_q  <= t5_q;
    b6_q  <= b5_q;
    d6_q  <= d5_q;
    e6_q  <= e5_q;
    m6_q  <= mon_prod[21:18];
    h6_q  <= h5_q;
    mi6_q <= mi5_q;
    s6_q  <= s5_q;
  end

  // Stage 7: month, day and year
  logic        hi;
  logic [15:0] yr;
  always_comb begin
    hi = (m6_q >= 4'd10);
    yr = 16'd100 * {9'd0, b6_q} + {9'd0, d6_q} + {15'd0, hi} - 16'd6800;
  end
  always_ff @(posedge clk_i) if (en_i) begin
    rsp_o.epoch_out  <= t6_q;
    rsp_o.year_out   <= yr[7:0];
    rsp_o.month_out  <= hi ? 4'(m6_q - 4'd9) : 4'(m6_q + 4'd3);
    rsp_o.day_out    <= 5'(e6_q - ecc_pkg::month_days(m6_q) + 9'd1);
    rsp_o.hour_out   <= h6_q;
    rsp_o.minute_out <= mi6_q;
    rsp_o.second_out <= s6_q;
  end
endmodule

/* hw/rtl/epoch_calendar_converter_core.sv */
// Top level of the epoch calendar converter: ten-stage pipeline with valid tracking.
//  channel | dir | payload
//  req     | in  | mode, epoch, date/time fields, add amount
//  rsp     | out | epoch and date/time fields
// One request per cycle unless the response side stalls; each answer comes out of the last stage.
// Reset clears the valid bits only. A stall on the response side freezes the
// whole pipeline; ready drops only when the last stage holds a response
// that is not being taken, so nothing is lost or repeated.
`timescale 1ns / 1ps
module epoch_calendar_converter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecc_req_if.sink    req_i,
  ecc_rsp_if.source  rsp_o
);
  localparam int unsigned Stages = ecc_pkg::ToEpochStages + ecc_pkg::SplitStages;
  logic [Stages-1:0] vld_q;
  logic              en;
  logic [31:0]       epoch;

  assign en          = !vld_q[Stages-1] || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], req_i.valid};
    end
  end

  ecc_to_epoch u_to_epoch (.clk_i, .en_i(en), .req_i(req_i.data), .epoch_o(epoch));
  ecc_split    u_split    (.clk_i, .en_i(en), .epoch_i(epoch), .rsp_o(rsp_o.data));
endmodule
